/* hdl/aad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_pkg
// Shared types and constants of the area average downscaler.
// ----------------------------------------------------------------------------
package aad_pkg;

    localparam int COL_LIMIT = 256;
    localparam int MAX_DIM   = 4096;
    localparam int ROW_LIMIT = 1024;

    // configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_CELL_COLS    = 3'd2;
    localparam logic [2:0] REG_CELL_ROWS    = 3'd3;

    // per column accumulator entry
    typedef struct packed {
        logic [31:0] sum_r;
        logic [31:0] sum_g;
        logic [31:0] sum_b;
        logic [24:0] cnt;
    } t_acc;

    // finished cell handed from front to back
    typedef struct packed {
        logic [7:0]  col;
        logic [9:0]  row;
        logic        done;
        t_acc        acc;
    } t_cell;

endpackage

/* hdl/aad_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_fifo
// Two entry queue of finished cells between front and back.
// ----------------------------------------------------------------------------
module aad_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  aad_pkg::t_cell i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output aad_pkg::t_cell o_data
);
    import aad_pkg::*;

    t_cell      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, (i_push && !o_full)} - {1'b0, (i_pop && !o_empty)};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("cell queue count out of range");

endmodule

/* hdl/aad_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_front
// Configuration, raster position tracking, cell edges and column accumulators.
// ----------------------------------------------------------------------------
module aad_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    input  logic [2:0]     i_cfg_index,
    input  logic [12:0]    i_cfg_data,
    input  logic           i_push,
    output logic           o_full,
    input  logic [7:0]     i_pix_red,
    input  logic [7:0]     i_pix_green,
    input  logic [7:0]     i_pix_blue,
    output logic           o_cell_push,
    output aad_pkg::t_cell o_cell,
    input  logic           i_cell_full
);
    import aad_pkg::*;

    typedef enum logic [1:0] {S_INIT, S_SET, S_IDLE, S_ACC} t_state;

    t_state      r_state;
    logic [12:0] r_fw;
    logic [12:0] r_fh;
    logic [8:0]  r_cc;
    logic [10:0] r_cr;
    logic [3:0]  r_cnt;
    logic [12:0] r_wq;
    logic [8:0]  r_wrem;
    logic [12:0] r_hq;
    logic [10:0] r_hrem;
    logic [11:0] r_x;
    logic [11:0] r_y;
    logic [7:0]  r_col;
    logic [9:0]  r_row;
    logic [12:0] r_col_end;
    logic [8:0]  r_crem;
    logic [12:0] r_band_end;
    logic [10:0] r_rrem;
    logic [7:0]  r_pr;
    logic [7:0]  r_pg;
    logic [7:0]  r_pb;

    t_acc        r_mem [COL_LIMIT];
    logic [COL_LIMIT-1:0] r_vld;
    t_acc        r_rd;
    logic        r_rdv;

    logic [12:0] w_eff, h_eff;
    logic [8:0]  col_hi, cols_eff;
    logic [10:0] row_hi, rows_eff;
    logic [9:0]  t_w;
    logic        ge_w;
    logic [11:0] t_h;
    logic        ge_h;
    logic        cfg_hit;
    logic        col_last, band_last, emit, advance, rd_en;
    logic [9:0]  crem_sum;
    logic        cwrap;
    logic [12:0] col_end_nx;
    logic [11:0] rrem_sum;
    logic        rwrap;
    logic [12:0] band_end_nx;
    logic [12:0] x1, y1;
    logic        more_cols, more_rows;
    t_acc        base, acc_new, wdata;

    // effective geometry after clamping
    always_comb begin
        if (r_fw == 13'd0)              w_eff = 13'd1;
        else if (r_fw > 13'(MAX_DIM))   w_eff = 13'(MAX_DIM);
        else                            w_eff = r_fw;
        if (r_fh == 13'd0)              h_eff = 13'd1;
        else if (r_fh > 13'(MAX_DIM))   h_eff = 13'(MAX_DIM);
        else                            h_eff = r_fh;
        col_hi = (w_eff > 13'(COL_LIMIT)) ? 9'(COL_LIMIT) : w_eff[8:0];
        row_hi = (h_eff > 13'(ROW_LIMIT)) ? 11'(ROW_LIMIT) : h_eff[10:0];
        if (r_cc == 9'd0)               cols_eff = 9'd1;
        else if (r_cc > col_hi)         cols_eff = col_hi;
        else                            cols_eff = r_cc;
        if (r_cr == 11'd0)              rows_eff = 11'd1;
        else if (r_cr > row_hi)         rows_eff = row_hi;
        else                            rows_eff = r_cr;
    end

    // one quotient bit a cycle for width/cols and height/rows
    assign t_w  = {r_wrem, w_eff[4'd12 - r_cnt]};
    assign ge_w = t_w >= {1'b0, cols_eff};
    assign t_h  = {r_hrem, h_eff[4'd12 - r_cnt]};
    assign ge_h = t_h >= {1'b0, rows_eff};

    assign cfg_hit = i_cfg_valid && (i_cfg_index == REG_FRAME_WIDTH
        || i_cfg_index == REG_FRAME_HEIGHT || i_cfg_index == REG_CELL_COLS
        || i_cfg_index == REG_CELL_ROWS);

    assign col_last  = ({1'b0, r_x} + 13'd1) >= r_col_end;
    assign band_last = ({1'b0, r_y} + 13'd1) >= r_band_end;
    assign emit      = (r_state == S_ACC) && col_last && band_last;
    assign advance   = (r_state == S_ACC) && !(emit && i_cell_full);
    assign rd_en     = (r_state == S_IDLE) && i_push;

    // next edges by stepping quotient and remainder
    assign crem_sum    = {1'b0, r_crem} + {1'b0, r_wrem};
    assign cwrap       = crem_sum >= {1'b0, cols_eff};
    assign col_end_nx  = r_col_end + r_wq + {12'd0, cwrap};
    assign rrem_sum    = {1'b0, r_rrem} + {1'b0, r_hrem};
    assign rwrap       = rrem_sum >= {1'b0, rows_eff};
    assign band_end_nx = r_band_end + r_hq + {12'd0, rwrap};

    assign x1        = {1'b0, r_x} + 13'd1;
    assign y1        = {1'b0, r_y} + 13'd1;
    assign more_cols = ({1'b0, r_col} + 9'd1) < cols_eff;
    assign more_rows = ({1'b0, r_row} + 11'd1) < rows_eff;

    always_comb begin
        base          = r_rdv ? r_rd : '0;
        acc_new.sum_r = base.sum_r + {24'd0, r_pr};
        acc_new.sum_g = base.sum_g + {24'd0, r_pg};
        acc_new.sum_b = base.sum_b + {24'd0, r_pb};
        acc_new.cnt   = base.cnt + 25'd1;
        wdata         = emit ? '0 : acc_new;
    end

    assign o_full        = (r_state != S_IDLE);
    assign o_cell_push   = emit && !i_cell_full;
    assign o_cell.col    = r_col;
    assign o_cell.row    = r_row;
    assign o_cell.done   = !more_cols && !more_rows;
    assign o_cell.acc    = acc_new;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[r_col];
        end
        if (advance) begin
            r_mem[r_col] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_rdv <= 1'b0;
        end else begin
            if (r_state == S_INIT) begin
                r_vld <= '0;
            end else if (advance) begin
                r_vld[r_col] <= 1'b1;
            end
            if (rd_en) begin
                r_rdv <= r_vld[r_col];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_fw    <= 13'd640;
            r_fh    <= 13'd480;
            r_cc    <= 9'd80;
            r_cr    <= 11'd24;
            r_cnt   <= 4'd0;
            r_wq    <= 13'd0;
            r_wrem  <= 9'd0;
            r_hq    <= 13'd0;
            r_hrem  <= 11'd0;
        end else if (cfg_hit) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_fw <= i_cfg_data;
                REG_FRAME_HEIGHT: r_fh <= i_cfg_data;
                REG_CELL_COLS:    r_cc <= i_cfg_data[8:0];
                REG_CELL_ROWS:    r_cr <= i_cfg_data[10:0];
                default:          r_cc <= r_cc;
            endcase
            r_state <= S_INIT;
            r_cnt   <= 4'd0;
            r_wq    <= 13'd0;
            r_wrem  <= 9'd0;
            r_hq    <= 13'd0;
            r_hrem  <= 11'd0;
        end else begin
            case (r_state)
                S_INIT: begin
                    r_wrem <= ge_w ? 9'(t_w - {1'b0, cols_eff}) : t_w[8:0];
                    r_wq   <= {r_wq[11:0], ge_w};
                    r_hrem <= ge_h ? 11'(t_h - {1'b0, rows_eff}) : t_h[10:0];
                    r_hq   <= {r_hq[11:0], ge_h};
                    r_cnt  <= r_cnt + 4'd1;
                    if (r_cnt == 4'd12) begin
                        r_state <= S_SET;
                    end
                end
                S_SET: begin
                    r_x        <= 12'd0;
                    r_y        <= 12'd0;
                    r_col      <= 8'd0;
                    r_row      <= 10'd0;
                    r_col_end  <= r_wq;
                    r_crem     <= r_wrem;
                    r_band_end <= r_hq;
                    r_rrem     <= r_hrem;
                    r_state    <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_push) begin
                        r_pr    <= i_pix_red;
                        r_pg    <= i_pix_green;
                        r_pb    <= i_pix_blue;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (advance) begin
                        r_state <= S_IDLE;
                        if (x1 >= w_eff) begin
                            r_x       <= 12'd0;
                            r_col     <= 8'd0;
                            r_col_end <= r_wq;
                            r_crem    <= r_wrem;
                            if (y1 >= h_eff) begin
                                r_y        <= 12'd0;
                                r_row      <= 10'd0;
                                r_band_end <= r_hq;
                                r_rrem     <= r_hrem;
                            end else begin
                                r_y <= y1[11:0];
                                if (y1 >= r_band_end && more_rows) begin
                                    r_row      <= r_row + 10'd1;
                                    r_band_end <= band_end_nx;
                                    r_rrem     <= rwrap ? 11'(rrem_sum - {1'b0, rows_eff})
                                                        : rrem_sum[10:0];
                                end
                            end
                        end else begin
                            r_x <= x1[11:0];
                            if (col_last && more_cols) begin
                                r_col     <= r_col + 8'd1;
                                r_col_end <= col_end_nx;
                                r_crem    <= cwrap ? 9'(crem_sum - {1'b0, cols_eff})
                                                   : crem_sum[8:0];
                            end
                        end
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> r_state == S_INIT) else $error("config write did not restart");
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_push |-> acc_new.cnt != 25'd0) else $error("cell emitted with zero count");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> ({1'b0, r_col} < cols_eff))
        else $error("grid column beyond column count");

endmodule

/* hdl/aad_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aad_back
// Mean of each channel by shared restoring division, one bit a cycle.
// ----------------------------------------------------------------------------
module aad_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cell_empty,
    input  aad_pkg::t_cell i_cell,
    output logic           o_cell_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [7:0]     o_cell_col,
    output logic [9:0]     o_cell_row,
    output logic [7:0]     o_avg_red,
    output logic [7:0]     o_avg_green,
    output logic [7:0]     o_avg_blue,
    output logic           o_frame_done
);
    import aad_pkg::*;

    typedef enum logic {B_IDLE, B_DIV} t_bstate;

    t_bstate     r_state;
    logic [2:0]  r_cnt;
    logic [31:0] r_rem_r, r_rem_g, r_rem_b;
    logic [31:0] r_div;
    logic [7:0]  r_qr, r_qg, r_qb;
    logic [7:0]  r_col;
    logic [9:0]  r_row;
    logic        r_done;
    logic        r_zero;
    logic        r_ovld;
    logic        ge_r, ge_g, ge_b;

    assign ge_r = r_rem_r >= r_div;
    assign ge_g = r_rem_g >= r_div;
    assign ge_b = r_rem_b >= r_div;

    assign o_cell_pop   = (r_state == B_IDLE) && !i_cell_empty && !r_ovld;
    assign o_empty      = !r_ovld;
    assign o_cell_col   = r_col;
    assign o_cell_row   = r_row;
    assign o_frame_done = r_done;
    assign o_avg_red    = r_zero ? 8'd0 : r_qr;
    assign o_avg_green  = r_zero ? 8'd0 : r_qg;
    assign o_avg_blue   = r_zero ? 8'd0 : r_qb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ovld  <= 1'b0;
            r_cnt   <= 3'd0;
        end else begin
            if (i_pop && r_ovld) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (o_cell_pop) begin
                        r_rem_r <= i_cell.acc.sum_r;
                        r_rem_g <= i_cell.acc.sum_g;
                        r_rem_b <= i_cell.acc.sum_b;
                        // the mean is below 256, so eight quotient bits suffice
                        r_div   <= {i_cell.acc.cnt, 7'd0};
                        r_zero  <= (i_cell.acc.cnt == 25'd0);
                        r_col   <= i_cell.col;
                        r_row   <= i_cell.row;
                        r_done  <= i_cell.done;
                        r_cnt   <= 3'd7;
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rem_r <= ge_r ? r_rem_r - r_div : r_rem_r;
                    r_rem_g <= ge_g ? r_rem_g - r_div : r_rem_g;
                    r_rem_b <= ge_b ? r_rem_b - r_div : r_rem_b;
                    r_qr    <= {r_qr[6:0], ge_r};
                    r_qg    <= {r_qg[6:0], ge_g};
                    r_qb    <= {r_qb[6:0], ge_b};
                    r_div   <= {1'b0, r_div[31:1]};
                    r_cnt   <= r_cnt - 3'd1;
                    if (r_cnt == 3'd0) begin
                        r_ovld  <= 1'b1;
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_div_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> !r_ovld) else $error("result shown while dividing");
    a_result_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovld) |-> $past(r_state) == B_DIV) else $error("result without division");

endmodule

/* hdl/area_average_downscaler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// area_average_downscaler_core
// Box filter downscaler: raster RGB pixels in, one averaged result per cell.
// ----------------------------------------------------------------------------
// Usage
// Pixels enter through a queue style port: a request is taken on a clock edge
// with i_push high and o_full low. Results leave the same way: while o_empty
// is low the oldest cell is on the output ports, taken with i_pop high.
// Registers are written through i_cfg_valid/o_cfg_ready (always ready) with
// i_cfg_index and i_cfg_data; any write to a known register restarts the
// frame, as does reset. The restart runs the edge divisions, then loads the
// position, all with o_full high.
// Each pixel is taken in the idle state, which reads its column accumulator
// from memory; the accumulate state then adds and writes it back before
// another pixel is taken. A finished cell reaches the outputs after its last
// pixel passes the accumulate state, the two entry cell queue and a one bit
// a cycle division for the three channel means in parallel.
// If the receiver stalls, the result register and the cell queue fill; the
// front then holds o_full high on the next cell end until space frees up.
// ----------------------------------------------------------------------------
module area_average_downscaler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_pix_red,
    input  logic [7:0]  i_pix_green,
    input  logic [7:0]  i_pix_blue,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_cell_col,
    output logic [9:0]  o_cell_row,
    output logic [7:0]  o_avg_red,
    output logic [7:0]  o_avg_green,
    output logic [7:0]  o_avg_blue,
    output logic        o_frame_done
);
    import aad_pkg::*;

    t_cell f_cell;
    t_cell q_cell;
    logic  f_push, q_full, q_empty, q_pop;

    assign o_cfg_ready = 1'b1;

    aad_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_pix_red   (i_pix_red),
        .i_pix_green (i_pix_green),
        .i_pix_blue  (i_pix_blue),
        .o_cell_push (f_push),
        .o_cell      (f_cell),
        .i_cell_full (q_full)
    );

    aad_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_cell),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_cell)
    );

    aad_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_empty (q_empty),
        .i_cell       (q_cell),
        .o_cell_pop   (q_pop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_cell_col   (o_cell_col),
        .o_cell_row   (o_cell_row),
        .o_avg_red    (o_avg_red),
        .o_avg_green  (o_avg_green),
        .o_avg_blue   (o_avg_blue),
        .o_frame_done (o_frame_done)
    );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the area average downscaler core. Pixel requests
// come from a queue and are driven with random gaps. A model of the cell grid
// predicts each finished cell as its last pixel is taken. Results are popped
// with random stalls and checked field by field. Runs cover several frame and
// grid settings, including the register extremes and out of range values.
// ----------------------------------------------------------------------------
module testbench;
    import aad_pkg::*;

    localparam int  LIMIT_CYCLES = 3000000;
    localparam int  DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] col;
        logic [9:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       done;
    } t_cell_avg;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [7:0]  i_pix_red = '0;
    logic [7:0]  i_pix_green = '0;
    logic [7:0]  i_pix_blue = '0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic [7:0]  o_cell_col;
    logic [9:0]  o_cell_row;
    logic [7:0]  o_avg_red;
    logic [7:0]  o_avg_green;
    logic [7:0]  o_avg_blue;
    logic        o_frame_done;

    area_average_downscaler_core u_top (.*);

    always #4 i_clk = ~i_clk;

    // grid model state
    logic [12:0] reg_width, reg_height;
    logic [8:0]  reg_cols;
    logic [10:0] reg_rows;
    logic [31:0] sum_red [COL_LIMIT];
    logic [31:0] sum_green [COL_LIMIT];
    logic [31:0] sum_blue [COL_LIMIT];
    logic [24:0] pix_count [COL_LIMIT];
    int          pos_x, pos_y, grid_col, grid_row, col_edge, band_edge;

    t_pixel      pixel_q[$];
    t_cell_avg   cell_q[$];
    int          gap_left = 0;
    bit          gaps_on = 1'b1;
    int          hold_left = 0;
    int          errors = 0;
    int          cells_seen = 0;
    int          pixels_taken = 0;
    int          cycles = 0;
    int          phases = 0;

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int used_width();
        return clamp(reg_width, 1, MAX_DIM);
    endfunction

    function automatic int used_height();
        return clamp(reg_height, 1, MAX_DIM);
    endfunction

    function automatic int used_cols();
        return clamp(reg_cols, 1, (used_width() < COL_LIMIT) ? used_width() : COL_LIMIT);
    endfunction

    function automatic int used_rows();
        return clamp(reg_rows, 1, (used_height() < ROW_LIMIT) ? used_height() : ROW_LIMIT);
    endfunction

    function automatic void restart_grid();
        for (int k = 0; k < COL_LIMIT; k++) begin
            sum_red[k] = '0;
            sum_green[k] = '0;
            sum_blue[k] = '0;
            pix_count[k] = '0;
        end
        pos_x = 0;
        pos_y = 0;
        grid_col = 0;
        grid_row = 0;
        col_edge = used_width() / used_cols();
        band_edge = used_height() / used_rows();
    endfunction

    function automatic void write_reg(logic [2:0] idx, logic [12:0] val);
        case (idx)
            REG_FRAME_WIDTH:  reg_width = val;
            REG_FRAME_HEIGHT: reg_height = val;
            REG_CELL_COLS:    reg_cols = val[8:0];
            REG_CELL_ROWS:    reg_rows = val[10:0];
            default: return;
        endcase
        restart_grid();
    endfunction

    function automatic void accumulate_pixel(t_pixel p);
        int        w, h, cols, rows, c;
        t_cell_avg r;
        w = used_width();
        h = used_height();
        cols = used_cols();
        rows = used_rows();
        c = grid_col % COL_LIMIT;
        sum_red[c] += p.red;
        sum_green[c] += p.green;
        sum_blue[c] += p.blue;
        pix_count[c] += 25'd1;
        if (pos_x + 1 >= col_edge) begin
            if (pos_y + 1 >= band_edge) begin
                r.col = grid_col[7:0];
                r.row = grid_row[9:0];
                r.red = (pix_count[c] != 0) ? 8'(sum_red[c] / pix_count[c]) : 8'd0;
                r.green = (pix_count[c] != 0) ? 8'(sum_green[c] / pix_count[c]) : 8'd0;
                r.blue = (pix_count[c] != 0) ? 8'(sum_blue[c] / pix_count[c]) : 8'd0;
                r.done = (grid_col + 1 >= cols) && (grid_row + 1 >= rows);
                cell_q.push_back(r);
                sum_red[c] = '0;
                sum_green[c] = '0;
                sum_blue[c] = '0;
                pix_count[c] = '0;
            end
            if (grid_col + 1 < cols) begin
                grid_col++;
                col_edge = ((grid_col + 1) * w) / cols;
            end
        end
        pos_x++;
        if (pos_x >= w) begin
            pos_x = 0;
            grid_col = 0;
            col_edge = w / cols;
            pos_y++;
            if (pos_y >= h) begin
                pos_y = 0;
                grid_row = 0;
                band_edge = h / rows;
            end else if (pos_y >= band_edge && grid_row + 1 < rows) begin
                grid_row++;
                band_edge = ((grid_row + 1) * h) / rows;
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // pixel driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_push <= 1'b0;
        end else if (pixel_q.size() > 0) begin
            i_push <= 1'b1;
            {i_pix_red, i_pix_green, i_pix_blue} <= pixel_q[0];
        end else begin
            i_push <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !o_full) begin
            accumulate_pixel(pixel_q[0]);
            void'(pixel_q.pop_front());
            pixels_taken++;
            gap_left = pick_gap();
        end
    end

    // result receiver, with its own long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= !gaps_on || ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge i_clk) begin
        t_cell_avg e;
        if (i_rst_n && i_pop && !o_empty) begin
            cells_seen++;
            if (cell_q.size() == 0) begin
                $display("%0t: unexpected result col %0d row %0d", $time, o_cell_col,
                         o_cell_row);
                errors++;
            end else begin
                e = cell_q.pop_front();
                if ({o_cell_col, o_cell_row, o_avg_red, o_avg_green, o_avg_blue,
                     o_frame_done} != e) begin
                    $display("%0t: mismatch exp col %0d row %0d rgb %0d %0d %0d done %0d",
                             $time, e.col, e.row, e.red, e.green, e.blue, e.done);
                    $display("%0t:          got col %0d row %0d rgb %0d %0d %0d done %0d",
                             $time, o_cell_col, o_cell_row, o_avg_red, o_avg_green,
                             o_avg_blue, o_frame_done);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [12:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(int w, int h, int cols, int rows);
        cfg_write(REG_FRAME_WIDTH, 13'(w));
        cfg_write(REG_FRAME_HEIGHT, 13'(h));
        cfg_write(REG_CELL_COLS, 13'(cols));
        cfg_write(REG_CELL_ROWS, 13'(rows));
        phases++;
    endtask

    task automatic wait_idle();
        while (pixel_q.size() > 0 || cell_q.size() > 0) @(posedge i_clk);
        // pixels ending no cell may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_pixels(int n, bit extremes);
        t_pixel p;
        for (int k = 0; k < n; k++) begin
            if (extremes) begin
                p = {$urandom_range(0, 1) ? 8'hff : 8'h00, $urandom_range(0, 1) ? 8'hff : 8'h00,
                     $urandom_range(0, 1) ? 8'hff : 8'h00};
            end else begin
                p = 24'($urandom);
            end
            pixel_q.push_back(p);
        end
    endtask

    initial begin
        int w, h, cols, rows, n, random_items;
        reg_width = 13'd640;
        reg_height = 13'd480;
        reg_cols = 9'd80;
        reg_rows = 11'd24;
        restart_grid();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a few pixels on the reset grid, no cell ends
        add_pixels(5, 1'b0);
        wait_idle();
        // one pixel per cell, extreme colours
        set_grid(4, 4, 4, 4);
        add_pixels(16, 1'b1);
        wait_idle();
        // single pixel frame, every pixel ends a frame
        set_grid(1, 1, 1, 1);
        pixel_q.push_back('0);
        pixel_q.push_back('1);
        wait_idle();
        // out of range values clamp
        set_grid(0, 8191, 511, 2047);
        cfg_write(3'd5, 13'h1fff);
        add_pixels(3, 1'b1);
        wait_idle();
        // pixels of 255 in every channel over a single eight pixel cell
        set_grid(8, 1, 1, 1);
        repeat (8) pixel_q.push_back('1);
        wait_idle();
        // widest line, most columns, receiver held off to fill the block
        set_grid(4096, 1, 256, 1);
        hold_left = 600;
        add_pixels(1024, 1'b0);
        wait_idle();
        // uneven column edges with the most columns
        set_grid(300, 1, 256, 1);
        add_pixels(300, 1'b0);
        wait_idle();

        random_items = 0;
        while (random_items < 600) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 12);
            cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, w);
            rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, h);
            set_grid(w, h, cols, rows);
            n = w * h * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) n += $urandom_range(1, w * h);
            add_pixels(n, $urandom_range(0, 5) == 0);
            random_items += n;
            wait_idle();
        end
        gaps_on = 1'b1;

        $display("%0d pixels over %0d grid settings, %0d cells checked",
                 pixels_taken, phases, cells_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d errors", errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/aad_pkg.sv
hdl/aad_fifo.sv
hdl/aad_front.sv
hdl/aad_back.sv
hdl/area_average_downscaler_core.sv
tb/sv/testbench.sv
